// ----- sv/b64dec_pkg.sv -----
`default_nettype none

package b64dec_pkg;

	// Character classes above the sextet range
	localparam logic [6:0] CLS_INVALID = 7'h40;
	localparam logic [6:0] CLS_SKIPPED = 7'h41;
	localparam logic [6:0] CLS_PADDING = 7'h42;

	localparam logic [5:0] SEXTET_PLUS  = 6'h3e;
	localparam logic [5:0] SEXTET_SLASH = 6'h3f;

	localparam logic [7:0] CHAR_PAD = 8'h3d;

	localparam int TDATA_W = 16;

	typedef enum logic [2:0] {
		ERR_NONE           = 3'd0,
		ERR_INVALID        = 3'd1,
		ERR_MISPLACED_PAD  = 3'd2,
		ERR_TRUNCATED      = 3'd3,
		ERR_DATA_AFTER_PAD = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		PH_NORMAL   = 3'b001,
		PH_ONE_PAD  = 3'b010,
		PH_PAD_DONE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		err_t       status;
		logic       stream_end;
	} res_t;

	// Map a character code to its sextet value, or to a class code
	function automatic logic [6:0] classify(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'h00;
			if (c >= 8'h41 && c <= 8'h5a) begin
				t = c - 8'h41;
			end else if (c >= 8'h61 && c <= 8'h7a) begin
				t = c - 8'h61 + 8'd26;
			end else if (c >= 8'h30 && c <= 8'h39) begin
				t = c - 8'h30 + 8'd52;
			end else if (c == 8'h2b) begin
				t = {2'b00, SEXTET_PLUS};
			end else if (c == 8'h2f) begin
				t = {2'b00, SEXTET_SLASH};
			end else if (c == CHAR_PAD) begin
				t = {1'b0, CLS_PADDING};
			end else if (c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h20) begin
				t = {1'b0, CLS_SKIPPED};
			end else begin
				t = {1'b0, CLS_INVALID};
			end
			return t[6:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- sv/base64_stream_decoder.sv -----
// A result is registered into the result register, or into the skid register while the result register is held.
// Throughput: one character per cycle while the skid register is empty; the decode state updates in the accept cycle.
// A two-entry output stage (result register plus skid register) keeps tready high
// while one finished result waits on the master side.
// Reset (arst_n low, asynchronous): decode state cleared, no error, output stage empty.
`default_nettype none

module base64_stream_decoder (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire  [7:0]                         s_axis_tdata,  // [7:0] char_code
	input  wire                                s_axis_tlast,  // last
	output logic                               m_axis_tvalid,
	input  wire                                m_axis_tready,
	output logic [b64dec_pkg::TDATA_W-1:0]     m_axis_tdata,  // [7:0] data_byte, [10:8] status
	output logic                               m_axis_tuser,  // byte_valid
	output logic                               m_axis_tlast   // stream_end
);

	// Decode state
	logic [5:0]         left_q;
	logic [1:0]         group_q;
	b64dec_pkg::phase_t phase_q;
	b64dec_pkg::err_t   err_q;

	logic [5:0]         left_nxt;
	logic [1:0]         group_nxt;
	b64dec_pkg::phase_t phase_nxt;
	b64dec_pkg::err_t   err_nxt;
	b64dec_pkg::res_t   res;

	// Output stage
	logic             out_valid_q;
	b64dec_pkg::res_t out_q;
	logic             skid_valid_q;
	b64dec_pkg::res_t skid_q;

	logic accept;
	logic out_take;
	logic out_free;

	assign s_axis_tready = !skid_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_take      = out_valid_q && m_axis_tready;
	assign out_free      = !out_valid_q || out_take;

	// Decode one character against the current state
	always_comb begin
		logic [6:0] cls;
		logic [5:0] s;
		logic [7:0] byte_v;
		logic       valid_v;
		cls       = b64dec_pkg::classify(s_axis_tdata);
		s         = cls[5:0];
		byte_v    = 8'h00;
		valid_v   = 1'b0;
		left_nxt  = left_q;
		group_nxt = group_q;
		phase_nxt = phase_q;
		err_nxt   = err_q;

		if (err_q == b64dec_pkg::ERR_NONE) begin
			if (cls == b64dec_pkg::CLS_INVALID) begin
				err_nxt = b64dec_pkg::ERR_INVALID;
			end else if (cls == b64dec_pkg::CLS_SKIPPED) begin
				// whitespace: no effect
			end else if (cls == b64dec_pkg::CLS_PADDING) begin
				unique case (phase_q)
					b64dec_pkg::PH_NORMAL: begin
						if (group_q == 2'd3) begin
							phase_nxt = b64dec_pkg::PH_PAD_DONE;
						end else if (group_q == 2'd2) begin
							phase_nxt = b64dec_pkg::PH_ONE_PAD;
						end else begin
							err_nxt = b64dec_pkg::ERR_MISPLACED_PAD;
						end
					end
					b64dec_pkg::PH_ONE_PAD: begin
						phase_nxt = b64dec_pkg::PH_PAD_DONE;
					end
					default: begin
						err_nxt = b64dec_pkg::ERR_MISPLACED_PAD;
					end
				endcase
			end else if (phase_q != b64dec_pkg::PH_NORMAL) begin
				err_nxt = b64dec_pkg::ERR_DATA_AFTER_PAD;
			end else begin
				unique case (group_q)
					2'd0: begin
						left_nxt = s;
					end
					2'd1: begin
						byte_v   = {left_q, s[5:4]};
						left_nxt = {2'b00, s[3:0]};
						valid_v  = 1'b1;
					end
					2'd2: begin
						byte_v   = {left_q[3:0], s[5:2]};
						left_nxt = {4'b0000, s[1:0]};
						valid_v  = 1'b1;
					end
					default: begin
						byte_v   = {left_q[1:0], s};
						left_nxt = 6'd0;
						valid_v  = 1'b1;
					end
				endcase
				group_nxt = group_q + 2'd1;
			end

			// Completeness check at end of stream
			if (s_axis_tlast && err_nxt == b64dec_pkg::ERR_NONE) begin
				if ((phase_nxt == b64dec_pkg::PH_NORMAL && group_nxt != 2'd0) ||
				    phase_nxt == b64dec_pkg::PH_ONE_PAD) begin
					err_nxt = b64dec_pkg::ERR_TRUNCATED;
				end
			end
		end

		// Suppress data once an error is pending
		if (err_nxt != b64dec_pkg::ERR_NONE) begin
			valid_v = 1'b0;
			byte_v  = 8'h00;
		end

		res.data_byte  = byte_v;
		res.byte_valid = valid_v;
		res.status     = err_nxt;
		res.stream_end = s_axis_tlast;
	end

	// Advance decode state on each transaction; end of stream returns to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= 6'd0;
			group_q <= 2'd0;
			phase_q <= b64dec_pkg::PH_NORMAL;
			err_q   <= b64dec_pkg::ERR_NONE;
		end else if (accept) begin
			if (s_axis_tlast) begin
				left_q  <= 6'd0;
				group_q <= 2'd0;
				phase_q <= b64dec_pkg::PH_NORMAL;
				err_q   <= b64dec_pkg::ERR_NONE;
			end else begin
				left_q  <= left_nxt;
				group_q <= group_nxt;
				phase_q <= phase_nxt;
				err_q   <= err_nxt;
			end
		end
	end

	// Output stage control: result register refills from skid first, then from input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= skid_valid_q || accept;
			end
			if (out_free) begin
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Output stage payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end
		if (accept && !out_free) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, out_q.status, out_q.data_byte};
	assign m_axis_tuser  = out_q.byte_valid;
	assign m_axis_tlast  = out_q.stream_end;

	// Skid register is only occupied behind a full result register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while result register is empty");

	// End of stream returns the decoder to its reset state
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_axis_tlast |=> group_q == 2'd0 && left_q == 6'd0 &&
			phase_q == b64dec_pkg::PH_NORMAL && err_q == b64dec_pkg::ERR_NONE)
		else $error("decode state not cleared after end of stream");

	// An error stays until the end of stream
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !s_axis_tlast && err_q != b64dec_pkg::ERR_NONE |=> err_q == $past(err_q))
		else $error("sticky error changed before end of stream");

	// No decoded byte is flagged together with an error status
	a_valid_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.byte_valid |-> res.status == b64dec_pkg::ERR_NONE &&
			err_q == b64dec_pkg::ERR_NONE)
		else $error("byte flagged valid while an error is pending");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
module tb_top;

	import b64dec_pkg::*;

	// One character on the slave side, with an optional hand-typed result
	typedef struct {
		logic [7:0] ch;
		logic       lst;
		bit         typed;
		res_t       want;
	} stim_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	wire                 s_axis_tready;
	logic [7:0]          s_axis_tdata = 8'h00;   // [7:0] char_code
	logic                s_axis_tlast = 1'b0;    // last
	wire                 m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	wire [TDATA_W-1:0]   m_axis_tdata;           // [7:0] data_byte, [10:8] status
	wire                 m_axis_tuser;           // byte_valid
	wire                 m_axis_tlast;           // stream_end

	stim_t      char_q[$];
	res_t       decoded_q[$];
	int         err_cnt = 0;
	bit         no_idle = 1'b0;
	int         stall_left = 0;

	// Decoder state as predicted from the characters accepted so far
	logic [5:0] dec_left = 6'd0;
	logic [1:0] dec_pos = 2'd0;
	phase_t     dec_phase = PH_NORMAL;
	err_t       dec_err = ERR_NONE;

	base64_stream_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#400000;
		$display("tb_top: done, errors");
		$finish;
	end

	// Map a character to its sextet, or to a whitespace, padding or invalid class
	function automatic logic [6:0] char_class(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h41 && c <= 8'h5a) begin
			v = c - 8'h41;
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			v = c - 8'h47;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = c + 8'd4;
		end else if (c == 8'h2b) begin
			v = {2'b00, SEXTET_PLUS};
		end else if (c == 8'h2f) begin
			v = {2'b00, SEXTET_SLASH};
		end else if (c == CHAR_PAD) begin
			v = {1'b0, CLS_PADDING};
		end else if (c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h20) begin
			v = {1'b0, CLS_SKIPPED};
		end else begin
			v = {1'b0, CLS_INVALID};
		end
		return v[6:0];
	endfunction

	// Advance the predicted decoder by one character and return its result
	function automatic res_t predict_char(input logic [7:0] c, input logic lst);
		res_t       r;
		logic [6:0] cls;
		logic [5:0] s;
		r = '0;
		if (dec_err == ERR_NONE) begin
			cls = char_class(c);
			s = cls[5:0];
			case (cls)
				CLS_INVALID: dec_err = ERR_INVALID;
				CLS_SKIPPED: ;
				CLS_PADDING: begin
					if (dec_phase == PH_NORMAL) begin
						if (dec_pos == 2'd3)
							dec_phase = PH_PAD_DONE;
						else if (dec_pos == 2'd2)
							dec_phase = PH_ONE_PAD;
						else
							dec_err = ERR_MISPLACED_PAD;
					end else if (dec_phase == PH_ONE_PAD) begin
						dec_phase = PH_PAD_DONE;
					end else begin
						dec_err = ERR_MISPLACED_PAD;
					end
				end
				default: begin
					if (dec_phase != PH_NORMAL) begin
						dec_err = ERR_DATA_AFTER_PAD;
					end else begin
						// merge the leftover bits with the new sextet
						case (dec_pos)
							2'd0: dec_left = s;
							2'd1: begin
								r.data_byte = {dec_left, s[5:4]};
								r.byte_valid = 1'b1;
								dec_left = {2'b00, s[3:0]};
							end
							2'd2: begin
								r.data_byte = {dec_left[3:0], s[5:2]};
								r.byte_valid = 1'b1;
								dec_left = {4'b0000, s[1:0]};
							end
							default: begin
								r.data_byte = {dec_left[1:0], s};
								r.byte_valid = 1'b1;
								dec_left = 6'd0;
							end
						endcase
						dec_pos = dec_pos + 2'd1;
					end
				end
			endcase
			// check the group is complete at the end of the stream
			if (lst && dec_err == ERR_NONE &&
			    ((dec_phase == PH_NORMAL && dec_pos != 2'd0) || dec_phase == PH_ONE_PAD))
				dec_err = ERR_TRUNCATED;
		end
		if (dec_err != ERR_NONE) begin
			r.data_byte = 8'h00;
			r.byte_valid = 1'b0;
		end
		r.status = dec_err;
		r.stream_end = lst;
		if (lst) begin
			dec_left = 6'd0;
			dec_pos = 2'd0;
			dec_phase = PH_NORMAL;
			dec_err = ERR_NONE;
		end
		return r;
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] s);
		if (s < 6'd26)
			return 8'h41 + s;
		else if (s < 6'd52)
			return 8'h47 + s;
		else if (s < 6'd62)
			return s - 8'd4;
		else if (s == SEXTET_PLUS)
			return 8'h2b;
		return 8'h2f;
	endfunction

	function automatic logic [7:0] ws_char();
		case ($urandom_range(0, 3))
			0: return 8'h09;
			1: return 8'h0a;
			2: return 8'h0d;
			default: return 8'h20;
		endcase
	endfunction

	// Mix of raw codes, alphabet, padding and whitespace
	function automatic logic [7:0] noise_char();
		logic [7:0] raw;
		raw = 8'($urandom);
		case ($urandom_range(0, 3))
			0: return raw;
			1: return b64_char(raw[5:0]);
			2: return CHAR_PAD;
			default: return ws_char();
		endcase
	endfunction

	function automatic void add_item(input logic [7:0] ch, input logic lst);
		stim_t t;
		t.ch = ch;
		t.lst = lst;
		t.typed = 1'b0;
		t.want = '0;
		char_q.push_back(t);
	endfunction

	function automatic void add_typed(input logic [7:0] ch, input logic lst,
	                                  input logic [7:0] data, input logic valid, input err_t st);
		stim_t t;
		t.ch = ch;
		t.lst = lst;
		t.typed = 1'b1;
		t.want = '{data_byte: data, byte_valid: valid, status: st, stream_end: lst};
		char_q.push_back(t);
	endfunction

	// Encode random bytes; mode 0 clean, 1 one character replaced, 2 tail cut off
	function automatic void add_encoded(input int nbytes, input int mode);
		logic [7:0] txt[$];
		logic [7:0] b0, b1, b2;
		int         i;
		for (i = 0; i < nbytes; i += 3) begin
			b0 = 8'($urandom);
			b1 = 8'($urandom);
			b2 = 8'($urandom);
			txt.push_back(b64_char(b0[7:2]));
			txt.push_back(b64_char({b0[1:0], b1[7:4]}));
			txt.push_back((i + 1 < nbytes) ? b64_char({b1[3:0], b2[7:6]}) : CHAR_PAD);
			txt.push_back((i + 2 < nbytes) ? b64_char(b2[5:0]) : CHAR_PAD);
		end
		if (mode == 1 && txt.size() > 0)
			txt[$urandom_range(0, txt.size() - 1)] = noise_char();
		if (mode == 2 && txt.size() > 0)
			repeat ($urandom_range(1, 2)) txt.pop_back();
		foreach (txt[k]) begin
			if ($urandom_range(0, 7) == 0)
				add_item(ws_char(), 1'b0);
			add_item(txt[k], 1'b0);
		end
		// close the stream on the final character or on trailing whitespace
		if (txt.size() == 0 || $urandom_range(0, 3) == 0)
			add_item(ws_char(), 1'b1);
		else
			char_q[char_q.size() - 1].lst = 1'b1;
	endfunction

	// Hold tready low in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 3);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each master-side transaction with the oldest prediction
	always @(negedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result: data=%02h valid=%0b status=%0d end=%0b",
					         m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[10:8], m_axis_tlast);
			end else begin
				want = decoded_q.pop_front();
				if (m_axis_tdata[7:0] !== want.data_byte ||
				    m_axis_tdata[10:8] !== want.status ||
				    m_axis_tuser !== want.byte_valid || m_axis_tlast !== want.stream_end) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display({"mismatch: exp data=%02h valid=%0b status=%0d end=%0b,",
						          " got data=%02h valid=%0b status=%0d end=%0b"},
						         want.data_byte, want.byte_valid, want.status, want.stream_end,
						         m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[10:8],
						         m_axis_tlast);
				end
			end
		end
	end

	// Build the stimulus, then drive it one slave-side transaction at a time
	initial begin
		int i;
		int pick;
		bit accepted;
		res_t pred;

		// complete groups, all-ones byte, plus and slash, tab inside a group
		add_item(8'h54, 1'b0);                              // T
		add_item(8'h57, 1'b0);                              // W
		add_item(8'h46, 1'b0);                              // F
		add_item(8'h75, 1'b0);                              // u
		add_typed(8'h2f, 1'b0, 8'h00, 1'b0, ERR_NONE);      // /
		add_typed(8'h2f, 1'b0, 8'hff, 1'b1, ERR_NONE);      // /
		add_item(8'h2b, 1'b0);                              // +
		add_item(8'h09, 1'b0);
		add_item(8'h39, 1'b1);                              // 9
		// double padding with nonzero pad bits and a line feed between the pads
		add_item(8'h51, 1'b0);                              // Q
		add_item(8'h52, 1'b0);                              // R
		add_item(CHAR_PAD, 1'b0);
		add_item(8'h0a, 1'b0);
		add_item(CHAR_PAD, 1'b1);
		// padding at the start of a group
		add_typed(CHAR_PAD, 1'b1, 8'h00, 1'b0, ERR_MISPLACED_PAD);
		// high codes are invalid and the error sticks to the end of the stream
		add_typed(8'h80, 1'b0, 8'h00, 1'b0, ERR_INVALID);
		add_typed(8'h41, 1'b0, 8'h00, 1'b0, ERR_INVALID);
		add_typed(8'hff, 1'b1, 8'h00, 1'b0, ERR_INVALID);
		// lone sextet at the end of the stream
		add_typed(8'h51, 1'b1, 8'h00, 1'b0, ERR_TRUNCATED);
		// data after a single pad
		add_item(8'h51, 1'b0);
		add_item(8'h51, 1'b0);
		add_item(CHAR_PAD, 1'b0);
		add_typed(8'h7a, 1'b1, 8'h00, 1'b0, ERR_DATA_AFTER_PAD);
		add_typed(8'h00, 1'b1, 8'h00, 1'b0, ERR_INVALID);
		// stream of whitespace only
		add_typed(8'h20, 1'b1, 8'h00, 1'b0, ERR_NONE);

		// random streams, mostly well formed
		while (char_q.size() < 1025) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				add_encoded($urandom_range(0, 9), 0);
			end else if (pick < 16) begin
				add_encoded($urandom_range(1, 9), 1);
			end else if (pick < 18) begin
				add_encoded($urandom_range(1, 9), 2);
			end else begin
				repeat ($urandom_range(0, 5)) add_item(noise_char(), 1'b0);
				add_item(noise_char(), 1'b1);
			end
		end

		wait (arst_n === 1'b1);
		@(posedge clk);
		for (i = 0; i < char_q.size(); i++) begin
			if (i >= char_q.size() - 150)
				no_idle = 1'b1;
			if (!no_idle && $urandom_range(0, 3) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= char_q[i].ch;
			s_axis_tlast <= char_q[i].lst;
			// sample tready between edges to see whether the next edge accepts
			accepted = 1'b0;
			while (!accepted) begin
				@(negedge clk);
				accepted = s_axis_tready;
				if (accepted) begin
					pred = predict_char(char_q[i].ch, char_q[i].lst);
					decoded_q.push_back(char_q[i].typed ? char_q[i].want : pred);
				end
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;

		// drain the output stage
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/b64dec_pkg.sv
sv/base64_stream_decoder.sv
tb/tb_top.sv
